[src/sli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef logic [OP_W-1:0]            op_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    localparam status_t ST_INSERTED     = 3'd0;
    localparam status_t ST_DELETED      = 3'd1;
    localparam status_t ST_NOT_FOUND    = 3'd2;
    localparam status_t ST_FULL         = 3'd3;
    localparam status_t ST_READ_OK      = 3'd4;
    localparam status_t ST_OUT_OF_RANGE = 3'd5;

endpackage

`default_nettype wire

[src/sli_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module sli_mem #(
    parameter int CAPACITY = sli_pkg::DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire sli_pkg::value_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output sli_pkg::value_t      rdata
);
    import sli_pkg::*;

    value_t mem [CAPACITY];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/sli_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sli_ctrl #(
    parameter int CAPACITY = sli_pkg::DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire sli_pkg::op_t     operation,
    input  wire sli_pkg::value_t  item_value,
    input  wire sli_pkg::index_t  read_index,
    output logic                  busy,
    output logic                  done,
    output sli_pkg::status_t      status,
    output sli_pkg::value_t       result_value,
    output sli_pkg::index_t       entry_position,
    output sli_pkg::count_t       entry_count,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output sli_pkg::value_t       mem_wdata,
    output logic [AW-1:0]         mem_raddr,
    input  wire sli_pkg::value_t  mem_rdata
);
    import sli_pkg::*;

    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;

    logic [1:0]    state_reg, state_next;
    op_t           op_reg, op_next;
    value_t        val_reg, val_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          shift_reg, shift_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    value_t        result_reg, result_next;
    logic [AW-1:0] pos_reg, pos_next;

    logic [AW-1:0] last_idx;
    logic          at_last;

    assign last_idx = AW'(count_reg - CW'(1));
    assign at_last  = (idx_reg == last_idx);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = val_reg;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    val_next   = item_value;
                    shift_next = 1'b0;
                    unique case (operation)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                                result_next = '0;
                                pos_next    = '0;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = '0;
                                mem_wdata   = item_value;
                                count_next  = CW'(1);
                                done_next   = 1'b1;
                                status_next = ST_INSERTED;
                                result_next = item_value;
                                pos_next    = '0;
                            end
                            else
                            begin
                                // walk down from the top entry
                                mem_raddr  = last_idx;
                                idx_next   = last_idx;
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                                result_next = '0;
                                pos_next    = '0;
                            end
                            else
                            begin
                                // walk up from the bottom entry
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (XW'(read_index) >= XW'(count_reg))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OUT_OF_RANGE;
                                result_next = '0;
                                pos_next    = '0;
                            end
                            else
                            begin
                                mem_raddr  = AW'(read_index);
                                idx_next   = AW'(read_index);
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg + AW'(1);
                        if (mem_rdata > val_reg)
                        begin
                            // move the larger entry up one slot
                            mem_wdata = mem_rdata;
                            if (idx_reg == '0)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                mem_raddr = idx_reg - AW'(1);
                                idx_next  = idx_reg - AW'(1);
                            end
                        end
                        else
                        begin
                            mem_wdata   = val_reg;
                            count_next  = count_reg + CW'(1);
                            done_next   = 1'b1;
                            status_next = ST_INSERTED;
                            result_next = val_reg;
                            pos_next    = idx_reg + AW'(1);
                            state_next  = S_IDLE;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (shift_reg)
                        begin
                            // close the gap: move entry down one slot
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg - AW'(1);
                            mem_wdata = mem_rdata;
                            if (at_last)
                            begin
                                count_next  = count_reg - CW'(1);
                                done_next   = 1'b1;
                                status_next = ST_DELETED;
                                result_next = val_reg;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                mem_raddr = idx_reg + AW'(1);
                                idx_next  = idx_reg + AW'(1);
                            end
                        end
                        else if (mem_rdata == val_reg)
                        begin
                            pos_next = idx_reg;
                            if (at_last)
                            begin
                                count_next  = count_reg - CW'(1);
                                done_next   = 1'b1;
                                status_next = ST_DELETED;
                                result_next = val_reg;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                shift_next = 1'b1;
                                mem_raddr  = idx_reg + AW'(1);
                                idx_next   = idx_reg + AW'(1);
                            end
                        end
                        else if ((mem_rdata > val_reg) || at_last)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                            result_next = '0;
                            pos_next    = '0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            mem_raddr = idx_reg + AW'(1);
                            idx_next  = idx_reg + AW'(1);
                        end
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_READ_OK;
                        result_next = mem_rdata;
                        pos_next    = idx_reg;
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_PLACE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = '0;
                mem_wdata   = val_reg;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = ST_INSERTED;
                result_next = val_reg;
                pos_next    = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        result_reg <= result_next;
        pos_reg    <= pos_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign result_value   = result_reg;
    assign entry_position = INDEX_W'(pos_reg);
    assign entry_count    = COUNT_W'(count_reg);

endmodule

`default_nettype wire

[src/sorted_list_insert_delete.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sorted store of signed 32-bit values, kept in ascending order in one
// synchronous memory of CAPACITY entries.
// Command channel: drive operation, item_value and read_index with start;
// the transfer happens on a rising edge where start is high and busy low.
// Operations: insert (placed after equal values), delete (first equal
// entry), read (entry at read_index).
// Result channel: done pulses for one cycle with status, result_value,
// entry_position and entry_count; the receiver must take it then, since
// it cannot stall the block. A new command may be given in that cycle.
// Refused commands (full, not found on an empty store, index out of
// range) and an insert into an empty store are answered straight from
// idle, without a walk. A read takes a single memory access. An insert
// walks down from the top entry to where it lands, and a delete walks
// up from the bottom through at most the stored count of entries; the
// memory's single read and single write port move one entry per cycle in a walk.
// Reset clears the count and the control state; the memory itself is not
// cleared, since entries at or above the count are never read.

module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::DEFAULT_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sli_pkg::op_t     operation,
    input  wire sli_pkg::value_t  item_value,
    input  wire sli_pkg::index_t  read_index,
    output logic                  done,
    output sli_pkg::status_t      status,
    output sli_pkg::value_t       result_value,
    output sli_pkg::index_t       entry_position,
    output sli_pkg::count_t       entry_count
);
    import sli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // memory port between sequencer and store
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    value_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    value_t        mem_rdata;

    // sequencer: search and shift one entry per cycle
    sli_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .item_value     (item_value),
        .read_index     (read_index),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .result_value   (result_value),
        .entry_position (entry_position),
        .entry_count    (entry_count),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // entry store, read data in the cycle after the address
    sli_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[bench/sli_checker.sv]
`timescale 1ns / 1ps

module sli_checker #(
    parameter int CAPACITY = sli_pkg::DEFAULT_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire sli_pkg::op_t     operation,
    input  wire sli_pkg::value_t  item_value,
    input  wire sli_pkg::index_t  read_index,
    input  wire logic             done,
    input  wire sli_pkg::status_t status,
    input  wire sli_pkg::value_t  result_value,
    input  wire sli_pkg::index_t  entry_position,
    input  wire sli_pkg::count_t  entry_count,
    output int                    fail_count,
    output int                    pending
);

    import sli_pkg::*;

    typedef struct packed {
        status_t status;
        value_t  value;
        index_t  position;
        count_t  count;
    } outcome_t;

    // Shadow copy of the store, ascending; only entries below held are live.
    value_t   ladder [CAPACITY];
    int       held = 0;
    outcome_t outcome_q [$];

    // Apply one command to the shadow store and return the outcome it must produce.
    function automatic outcome_t apply_command(op_t op, value_t v, index_t idx);
        outcome_t res;
        int       pos;
        int       i;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (held >= CAPACITY) begin
                    res.status = ST_FULL;
                end
                else begin
                    pos = 0;
                    while (pos < held && ladder[pos] <= v)
                        pos++;
                    for (i = held; i > pos; i--)
                        ladder[i] = ladder[i - 1];
                    ladder[pos] = v;
                    held++;
                    res.status   = ST_INSERTED;
                    res.value    = v;
                    res.position = index_t'(pos);
                end
            end
            OP_DELETE: begin
                pos = 0;
                while (pos < held && ladder[pos] < v)
                    pos++;
                if (pos >= held || ladder[pos] != v) begin
                    res.status = ST_NOT_FOUND;
                end
                else begin
                    for (i = pos; i + 1 < held; i++)
                        ladder[i] = ladder[i + 1];
                    held--;
                    res.status   = ST_DELETED;
                    res.value    = v;
                    res.position = index_t'(pos);
                end
            end
            default: begin
                // the spare code reads like OP_READ
                if (int'(idx) >= held) begin
                    res.status = ST_OUT_OF_RANGE;
                end
                else begin
                    res.status   = ST_READ_OK;
                    res.value    = ladder[idx];
                    res.position = idx;
                end
            end
        endcase
        res.count = count_t'(held);
        return res;
    endfunction

    always @(posedge clk) begin
        outcome_t got;
        outcome_t want;
        if (!rst_n) begin
            held = 0;
            outcome_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // check the result before queuing a command taken at the same edge
            if (done) begin
                got = '{status, result_value, entry_position, entry_count};
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result, actual status %0d value %0d pos %0d count %0d",
                             $time, got.status, $signed(got.value), got.position, got.count);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected status %0d value %0d pos %0d count %0d",
                                 $time, want.status, $signed(want.value), want.position,
                                 want.count);
                        $display("%0t:           actual status %0d value %0d pos %0d count %0d",
                                 $time, got.status, $signed(got.value), got.position,
                                 got.count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_command(operation, item_value, read_index));
            pending <= outcome_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import sli_pkg::*;

    // Unused opcode; the block must treat it as a read.
    localparam op_t OP_SPARE = 2'd3;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7fff_ffff;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    op_t     operation;
    value_t  item_value;
    index_t  read_index;
    logic    done;
    status_t status;
    value_t  result_value;
    index_t  entry_position;
    count_t  entry_count;
    int      fail_count;
    int      pending;

    // Percentage of cycles in which the sender holds start low between commands.
    int      gap_pct;

    sorted_list_insert_delete uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .item_value     (item_value),
        .read_index     (read_index),
        .done           (done),
        .status         (status),
        .result_value   (result_value),
        .entry_position (entry_position),
        .entry_count    (entry_count)
    );

    // The checker sees the same ports, tracks every command transfer and
    // compares each done strobe against the oldest predicted outcome.
    sli_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .item_value     (item_value),
        .read_index     (read_index),
        .done           (done),
        .status         (status),
        .result_value   (result_value),
        .entry_position (entry_position),
        .entry_count    (entry_count),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 2000 commands, each
    // a walk through at most the full store, plus sender gaps).
    initial
    begin
        #5_000_000;
        $display("FAIL sorted_list_insert_delete");
        $finish;
    end

    // Issue one command. Before raising start, idle for a random number of
    // cycles and scramble the payload so the block must ignore it while
    // start is low. Then hold start until the transfer edge (busy low).
    task automatic send(op_t op, value_t v, index_t idx);
        while ($urandom_range(99) < gap_pct)
        begin
            start      <= 1'b0;
            operation  <= op_t'($urandom_range(3));
            item_value <= value_t'($urandom);
            read_index <= index_t'($urandom_range(15));
            @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        item_value <= v;
        read_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Values drawn most often from a narrow band so that duplicates pile up and
    // deletes find their target; extremes and full-width noise mixed in.
    function automatic value_t pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_MIN + value_t'($urandom_range(2));
            3:       return VAL_MAX - value_t'($urandom_range(2));
            8, 9:    return value_t'($urandom);
            default: return value_t'($urandom_range(8)) - 4;
        endcase
    endfunction

    // Random traffic in bursts: a fill burst favors inserts and pushes the
    // store to full, a drain burst favors deletes and empties it, so both
    // the full and the empty corners come up again and again.
    task automatic run_traffic(int n_cmds);
        int k;
        int r;
        bit filling;
        filling = 1'b1;
        for (k = 0; k < n_cmds; k++)
        begin
            if (k % 32 == 0)
                filling = ($urandom_range(1) != 0);
            r = $urandom_range(99);
            if (r < (filling ? 60 : 20))
                send(OP_INSERT, pick_value(), index_t'($urandom_range(15)));
            else if (r < (filling ? 82 : 78))
                send(OP_DELETE, pick_value(), index_t'($urandom_range(15)));
            else if (r < 96)
                send(OP_READ, value_t'($urandom), index_t'($urandom_range(15)));
            else
                send(OP_SPARE, value_t'($urandom), index_t'($urandom_range(15)));
        end
    endtask

    initial
    begin
        int k;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        operation  <= OP_READ;
        item_value <= '0;
        read_index <= '0;
        gap_pct     = 15;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store corners first.
        send(OP_READ, value_t'($urandom), 4'd0);
        send(OP_DELETE, 32'sd5, 4'd0);

        // Extremes, zero, minus one, and a duplicate that must land after its twin.
        send(OP_INSERT, VAL_MIN, 4'd15);
        send(OP_INSERT, VAL_MAX, 4'd15);
        send(OP_INSERT, 32'sd0, 4'd0);
        send(OP_INSERT, -32'sd1, 4'd0);
        send(OP_INSERT, 32'sd7, 4'd0);
        send(OP_INSERT, 32'sd7, 4'd0);

        // Reads: first entry, spare opcode, and an index past the count.
        send(OP_READ, value_t'($urandom), 4'd0);
        send(OP_SPARE, value_t'($urandom), 4'd5);
        send(OP_READ, value_t'($urandom), 4'd15);

        // Delete a value that falls between stored entries, then real deletes.
        send(OP_DELETE, 32'sd3, 4'd0);
        send(OP_DELETE, 32'sd7, 4'd0);
        send(OP_DELETE, VAL_MIN, 4'd0);
        send(OP_DELETE, VAL_MAX, 4'd0);

        // Fill to capacity, bounce off the full store, read the top slot.
        for (k = 0; k < 13; k++)
            send(OP_INSERT, pick_value(), 4'd0);
        send(OP_INSERT, 32'sd1, 4'd0);
        send(OP_READ, value_t'($urandom), 4'd15);
        send(OP_DELETE, 32'sd0, 4'd0);

        // Random phases: light gaps, heavy gaps, then back to back.
        run_traffic(620);
        gap_pct = 50;
        run_traffic(650);
        gap_pct = 0;
        run_traffic(650);

        // Drop start, drain the outstanding results, then allow the longest
        // walk through the store so a stray extra strobe is still caught.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("PASS sorted_list_insert_delete");
        else
            $display("FAIL sorted_list_insert_delete");
        $finish;
    end

endmodule
